// ----- hw/rtl/gossip_membership_table_macros.svh -----
// Assertion macros for the gossip membership table.
`ifndef GOSSIP_MEMBERSHIP_TABLE_MACROS_SVH
`define GOSSIP_MEMBERSHIP_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define GMT_ASSERT_SAME(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);
// Check that a condition implies another in the next cycle.
`define GMT_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);
`else
`define GMT_ASSERT_SAME(lbl, cond, prop, msg)
`define GMT_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

// ----- hw/rtl/gmt_pkg.sv -----
// Types and codes shared by the gossip membership table modules.
package gmt_pkg;

    localparam int ID_W    = 32;
    localparam int PORT_W  = 16;
    localparam int BEAT_W  = 32;
    localparam int TIME_W  = 32;
    localparam int AGE_W   = 16;
    localparam int REP_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Report codes
    localparam logic [REP_W-1:0] REP_ADDED   = 3'd0;
    localparam logic [REP_W-1:0] REP_UPDATED = 3'd1;
    localparam logic [REP_W-1:0] REP_IGNORED = 3'd2;
    localparam logic [REP_W-1:0] REP_FULL    = 3'd3;
    localparam logic [REP_W-1:0] REP_REMOVED = 3'd4;
    localparam logic [REP_W-1:0] REP_ALIVE   = 3'd5;
    localparam logic [REP_W-1:0] REP_DONE    = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_ID     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SELF_PORT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_TIME = 3'd3;

    // Item kinds
    localparam logic KIND_GOSSIP = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Command passed from front to back
    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [BEAT_W-1:0] beat;
    } cmd_t;

    // Handshake from front to back
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_chan_t;

    // Stored table entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PORT_W-1:0] port;
        logic [BEAT_W-1:0] beat;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    // Configuration seen by the back end
    typedef struct packed {
        logic [ID_W-1:0]   self_id;
        logic [PORT_W-1:0] self_port;
        logic [AGE_W-1:0]  fail_time;
        logic [AGE_W-1:0]  remove_time;
    } cfg_t;

endpackage

// ----- hw/rtl/gossip_membership_table.sv -----
// Top level of the gossip membership table with failure detection.
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   input   | s_valid/s_ready, s_* fields   | in
//   result  | m_valid/m_ready, m_* fields   | out
//   config  | cfg_valid/cfg_ready, cfg_*    | in
//
// Each item walks all DEPTH slots: an occupied slot is first read from memory,
// then evaluated, an empty one is skipped without a read, and the walk has a
// fetch step before it and a finish step after it. Result stalls hold the walk
// on the entry being reported.
// Reset empties the table and clears time and heartbeat at once.
// The two-entry command queue keeps accepting items while the walk runs, as long as it has room.
`include "gossip_membership_table_macros.svh"
module gossip_membership_table #(
    parameter int DEPTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [31:0]                   s_member_id,
    input  logic [15:0]                   s_member_port,
    input  logic [31:0]                   s_beat_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_report,
    output logic [31:0]                   m_out_id,
    output logic [15:0]                   m_out_port,
    output logic [31:0]                   m_out_beat,
    output logic                          m_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gmt_pkg::*;

    cmd_chan_t cmd_chan;
    logic      cmd_pop;
    cfg_t      cfg_reg;

    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{self_id: '0, self_port: '0,
                         fail_time: AGE_W'(5), remove_time: AGE_W'(20)};
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SELF_ID:     cfg_reg.self_id     <= cfg_data;
                CFG_SELF_PORT:   cfg_reg.self_port   <= cfg_data[PORT_W-1:0];
                CFG_FAIL_TIME:   cfg_reg.fail_time   <= cfg_data[AGE_W-1:0];
                CFG_REMOVE_TIME: cfg_reg.remove_time <= cfg_data[AGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    gmt_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_member_id   (s_member_id),
        .s_member_port (s_member_port),
        .s_beat_count  (s_beat_count),
        .cmd_out       (cmd_chan),
        .cmd_pop       (cmd_pop)
    );

    gmt_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_in     (cmd_chan),
        .cmd_pop    (cmd_pop),
        .cfg        (cfg_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_report   (m_report),
        .m_out_id   (m_out_id),
        .m_out_port (m_out_port),
        .m_out_beat (m_out_beat),
        .m_last     (m_last)
    );

    `GMT_ASSERT_SAME(a_done_is_last, m_valid && m_report == REP_DONE, m_last, "done not last")
    `GMT_ASSERT_SAME(a_walk_not_last, m_valid && (m_report == REP_ALIVE || m_report == REP_REMOVED), !m_last, "walk result marked last")
    `GMT_ASSERT_SAME(a_known_report, m_valid, m_report <= REP_DONE, "undefined report code")
    `GMT_ASSERT_NEXT(a_pop_needs_cmd, cmd_pop, !(cmd_pop && !cmd_chan.valid), "pop without command")

endmodule

// ----- hw/rtl/gmt_front.sv -----
// Front end: accepts input items into a two-entry command queue.
module gmt_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [31:0]           s_member_id,
    input  logic [15:0]           s_member_port,
    input  logic [31:0]           s_beat_count,
    output gmt_pkg::cmd_chan_t    cmd_out,
    input  logic                  cmd_pop
);
    import gmt_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign pop     = cmd_pop && (cnt_reg != 2'd0);

    assign cmd_out.valid = (cnt_reg != 2'd0);
    assign cmd_out.cmd   = q_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the accepted item
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= '{kind: s_kind, id: s_member_id,
                                   port: s_member_port, beat: s_beat_count};
        end
    end

endmodule

// ----- hw/rtl/gmt_back.sv -----
// Back end: walks the membership table for each command and drives results.
module gmt_back #(
    parameter int DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gmt_pkg::cmd_chan_t    cmd_in,
    output logic                  cmd_pop,
    input  gmt_pkg::cfg_t         cfg,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [2:0]            m_report,
    output logic [31:0]           m_out_id,
    output logic [15:0]           m_out_port,
    output logic [31:0]           m_out_beat,
    output logic                  m_last
);
    import gmt_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    entry_t mem [DEPTH];
    entry_t rd_reg;

    logic [1:0]        state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    cmd_t              cmd_reg, cmd_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     fslot_reg, fslot_next;
    logic [BEAT_W-1:0] fbeat_reg, fbeat_next;
    logic              free_reg, free_next;
    logic [IW-1:0]     free_slot_reg, free_slot_next;
    logic [DEPTH-1:0]  valid_reg, valid_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [BEAT_W-1:0] own_reg, own_next;

    logic              m_valid_reg;
    logic [REP_W-1:0]  rep_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PORT_W-1:0] port_reg;
    logic [BEAT_W-1:0] beat_reg;
    logic              last_reg;

    logic              out_free;
    logic              emit;
    logic [REP_W-1:0]  em_rep;
    logic [ID_W-1:0]   em_id;
    logic [PORT_W-1:0] em_port;
    logic [BEAT_W-1:0] em_beat;
    logic              em_last;
    logic              rd_en;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    entry_t            wr_data;
    logic              at_last;
    logic              is_self;
    logic              is_key;
    logic [TIME_W-1:0] age;

    assign out_free = !m_valid_reg || m_ready;
    assign at_last  = (idx_reg == LAST_IDX);
    assign is_self  = (rd_reg.id == cfg.self_id) && (rd_reg.port == cfg.self_port);
    assign is_key   = (rd_reg.id == cmd_reg.id) && (rd_reg.port == cmd_reg.port);
    assign age      = time_reg - rd_reg.stamp;

    // Sequence one command over the table
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        found_next     = found_reg;
        fslot_next     = fslot_reg;
        fbeat_next     = fbeat_reg;
        free_next      = free_reg;
        free_slot_next = free_slot_reg;
        valid_next     = valid_reg;
        time_next      = time_reg;
        own_next       = own_reg;
        cmd_pop        = 1'b0;
        emit           = 1'b0;
        em_rep         = REP_DONE;
        em_id          = cfg.self_id;
        em_port        = cfg.self_port;
        em_beat        = own_reg;
        em_last        = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = '{id: cmd_reg.id, port: cmd_reg.port,
                           beat: cmd_reg.beat, stamp: time_reg};
        case (state_reg)
            ST_IDLE: begin
                if (cmd_in.valid) begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_in.cmd;
                    idx_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    if (cmd_in.cmd.kind == KIND_TICK) begin
                        time_next = time_reg + 1'b1;
                        own_next  = own_reg + 1'b1;
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (valid_reg[idx_reg]) begin
                    rd_en      = 1'b1;
                    state_next = ST_EVAL;
                end else begin
                    // Note lowest free slot, skip empty entry
                    if (cmd_reg.kind == KIND_GOSSIP && !free_reg) begin
                        free_next      = 1'b1;
                        free_slot_next = idx_reg;
                    end
                    state_next = at_last ? ST_FIN : ST_READ;
                    idx_next   = at_last ? idx_reg : idx_reg + 1'b1;
                end
            end
            ST_EVAL: begin
                if (cmd_reg.kind == KIND_GOSSIP) begin
                    if (is_key) begin
                        found_next = 1'b1;
                        fslot_next = idx_reg;
                        fbeat_next = rd_reg.beat;
                    end
                    state_next = at_last ? ST_FIN : ST_READ;
                    idx_next   = at_last ? idx_reg : idx_reg + 1'b1;
                end else if (out_free) begin
                    em_id   = rd_reg.id;
                    em_port = rd_reg.port;
                    em_beat = rd_reg.beat;
                    if (is_self) begin
                        // Refresh the self entry, which is then alive
                        emit    = 1'b1;
                        em_rep  = REP_ALIVE;
                        em_beat = own_reg;
                        wr_en   = 1'b1;
                        wr_data = '{id: rd_reg.id, port: rd_reg.port,
                                    beat: own_reg, stamp: time_reg};
                    end else if (age > TIME_W'(cfg.remove_time)) begin
                        emit                = 1'b1;
                        em_rep              = REP_REMOVED;
                        valid_next[idx_reg] = 1'b0;
                    end else if (age <= TIME_W'(cfg.fail_time)) begin
                        emit   = 1'b1;
                        em_rep = REP_ALIVE;
                    end
                    state_next = at_last ? ST_FIN : ST_READ;
                    idx_next   = at_last ? idx_reg : idx_reg + 1'b1;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    emit       = 1'b1;
                    em_last    = 1'b1;
                    state_next = ST_IDLE;
                    if (cmd_reg.kind == KIND_GOSSIP) begin
                        em_id   = cmd_reg.id;
                        em_port = cmd_reg.port;
                        em_beat = cmd_reg.beat;
                        if (found_reg) begin
                            if (cmd_reg.beat > fbeat_reg) begin
                                em_rep  = REP_UPDATED;
                                wr_en   = 1'b1;
                                wr_addr = fslot_reg;
                            end else begin
                                em_rep  = REP_IGNORED;
                                em_beat = fbeat_reg;
                            end
                        end else if (free_reg) begin
                            em_rep                    = REP_ADDED;
                            wr_en                     = 1'b1;
                            wr_addr                   = free_slot_reg;
                            valid_next[free_slot_reg] = 1'b1;
                        end else begin
                            em_rep = REP_FULL;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            time_reg    <= '0;
            own_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            time_reg  <= time_next;
            own_reg   <= own_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Walk state and result payload
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        cmd_reg       <= cmd_next;
        found_reg     <= found_next;
        fslot_reg     <= fslot_next;
        fbeat_reg     <= fbeat_next;
        free_reg      <= free_next;
        free_slot_reg <= free_slot_next;
        if (emit) begin
            rep_reg  <= em_rep;
            id_reg   <= em_id;
            port_reg <= em_port;
            beat_reg <= em_beat;
            last_reg <= em_last;
        end
    end

    // Table memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= mem[idx_reg];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_report   = rep_reg;
    assign m_out_id   = id_reg;
    assign m_out_port = port_reg;
    assign m_out_beat = beat_reg;
    assign m_last     = last_reg;

endmodule
